// ===== rtl/siphash_message_hasher_core_assert.svh =====
// Assertion macros for the SipHash core checks.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef SIPHASH_MESSAGE_HASHER_CORE_ASSERT_SVH
`define SIPHASH_MESSAGE_HASHER_CORE_ASSERT_SVH

// same-cycle implication
`define SIPH_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("siphash core check failed");

// next-cycle implication
`define SIPH_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("siphash core check failed");

`endif

// ===== rtl/siph_pkg.sv =====
// Shared types, constants and the SipRound function for the SipHash core.
// No dependencies.
package siph_pkg;

  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [63:0] KEY_LOW_RESET  = 64'h0706050403020100;
  localparam logic [63:0] KEY_HIGH_RESET = 64'h0f0e0d0c0b0a0908;
  localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;
  localparam logic [3:0]  FULL_BYTES = 4'd8;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW = 1;

  localparam int unsigned CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_KEY_HIGH = 2'd1;

  typedef enum logic [1:0] {
    OP_ABSORB,
    OP_FINAL,
    OP_FINAL2
  } op_t;

  typedef struct packed {
    logic        start;
    op_t         op;
    logic [63:0] m0;
    logic [63:0] m1;
  } q_entry_t;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BLOCK,
    BK_FIN
  } bk_state_t;

  typedef struct packed {
    logic idle;
    logic in_fin;
  } bk_stat_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned s);
    rotl = (x << s) | (x >> (64 - s));
  endfunction

  function automatic lanes_t siph_round(input lanes_t v);
    lanes_t r;
    r = v;
    r.v0 = r.v0 + r.v1;
    r.v2 = r.v2 + r.v3;
    r.v1 = rotl(r.v1, 13);
    r.v3 = rotl(r.v3, 16);
    r.v1 = r.v1 ^ r.v0;
    r.v3 = r.v3 ^ r.v2;
    r.v0 = rotl(r.v0, 32);
    r.v2 = r.v2 + r.v1;
    r.v0 = r.v0 + r.v3;
    r.v1 = rotl(r.v1, 17);
    r.v3 = rotl(r.v3, 21);
    r.v1 = r.v1 ^ r.v2;
    r.v3 = r.v3 ^ r.v0;
    r.v2 = rotl(r.v2, 32);
    return r;
  endfunction

  // keep bytes below count
  function automatic logic [63:0] byte_mask(input logic [3:0] count);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < count) m[i*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

// ===== rtl/siphash_message_hasher_core.sv =====
// SipHash-2-4 message hasher top level: key registers, front end, queue
// and round engine. Depends on siph_pkg, siph_front, siph_fifo, siph_back and the assertion header.
//
// Usage: message words enter on in_* (valid/ready), little-endian, first
// byte in bits 7..0; in_last_word closes the message and in_byte_count
// gives its valid bytes (9..15 count as 8). Non-last words are full words.
// One digest per message leaves on out_* (valid/ready).
// Key: cfg_index 0 writes key_low, 1 writes key_high, others are dropped;
// cfg_ready is always high. A new key applies from the next message start.
// Work per word is set by the single SipRound unit: two rounds per
// non-last word; a last word with 0..7 bytes takes six rounds, one with
// 8 bytes eight rounds (two blocks plus four finalization rounds).
// A last word passes the queue, the block and finalization rounds and
// the digest output register before out_valid rises.
// A two-entry queue lets the front take words while the engine works.
// If the receiver stalls, the engine holds its last finalization round
// until the output register frees; the queue then fills and in_ready drops.
// Reset (synchronous, rst_n low) empties the queue, closes any open
// message and restores the default key.
module siphash_message_hasher_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [63:0]                 in_msg_word,
  input  logic [3:0]                  in_byte_count,
  input  logic                        in_last_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [63:0]                 out_digest,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [siph_pkg::CFG_IW-1:0] cfg_index,
  input  logic [63:0]                 cfg_data
);
  import siph_pkg::*;

`include "siphash_message_hasher_core_assert.svh"

  logic [63:0] key_low_r, key_low_nxt;
  logic [63:0] key_high_r, key_high_nxt;
  logic        q_push, q_pop, q_full, q_nonempty;
  q_entry_t    wr_entry, rd_entry;
  bk_stat_t    bk_stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    key_low_nxt  = key_low_r;
    key_high_nxt = key_high_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low_nxt  = cfg_data;
        REG_KEY_HIGH: key_high_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= KEY_LOW_RESET;
      key_high_r <= KEY_HIGH_RESET;
    end else begin
      key_low_r  <= key_low_nxt;
      key_high_r <= key_high_nxt;
    end
  end

  siph_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_msg_word   (in_msg_word),
    .in_byte_count (in_byte_count),
    .in_last_word  (in_last_word),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (wr_entry)
  );

  siph_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .rd_entry (rd_entry),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  siph_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_nonempty),
    .q_entry    (rd_entry),
    .q_pop      (q_pop),
    .key_low    (key_low_r),
    .key_high   (key_high_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_digest (out_digest),
    .stat       (bk_stat)
  );

  `SIPH_CHECK(a_pop_nonempty, q_pop, q_nonempty && bk_stat.idle)
  `SIPH_CHECK_NEXT(a_pop_starts_work, q_pop, !bk_stat.idle)
  `SIPH_CHECK(a_digest_from_fin, $rose(out_valid), $past(bk_stat.in_fin))

endmodule

// ===== rtl/siph_front.sv =====
// Front end: accepts message words, tracks message start and length,
// and forms the blocks for the back end. Depends on siph_pkg.
module siph_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       in_msg_word,
  input  logic [3:0]        in_byte_count,
  input  logic              in_last_word,
  input  logic              q_full,
  output logic              q_push,
  output siph_pkg::q_entry_t q_entry
);
  import siph_pkg::*;

  logic       in_msg_r, in_msg_nxt;
  logic [7:0] len_r, len_nxt;
  logic [3:0] cnt_sat;
  logic [7:0] len_base;
  logic [7:0] len_sum;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    cnt_sat  = (in_byte_count > FULL_BYTES) ? FULL_BYTES : in_byte_count;
    len_base = in_msg_r ? len_r : 8'd0;
    len_sum  = len_base + (in_last_word ? {4'd0, cnt_sat} : 8'd8);

    q_entry.start = !in_msg_r;
    q_entry.m0    = in_msg_word;
    // full last word leaves an empty tail: mask of eight bytes zeroed below
    q_entry.m1    = {len_sum, 56'd0} |
                    ((cnt_sat == FULL_BYTES) ? 64'd0 : (in_msg_word & byte_mask(cnt_sat)));
    if (!in_last_word) q_entry.op = OP_ABSORB;
    else if (cnt_sat == FULL_BYTES) q_entry.op = OP_FINAL2;
    else q_entry.op = OP_FINAL;

    in_msg_nxt = in_msg_r;
    len_nxt    = len_r;
    if (q_push) begin
      in_msg_nxt = !in_last_word;
      len_nxt    = in_last_word ? 8'd0 : len_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      len_r    <= 8'd0;
    end else begin
      in_msg_r <= in_msg_nxt;
      len_r    <= len_nxt;
    end
  end

endmodule

// ===== rtl/siph_fifo.sv =====
// Two-entry queue between front and back end.
// Depends on siph_pkg.
module siph_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  siph_pkg::q_entry_t wr_entry,
  input  logic               pop,
  output siph_pkg::q_entry_t rd_entry,
  output logic               full,
  output logic               nonempty
);
  import siph_pkg::*;

  q_entry_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]    count_r, count_nxt;

  assign full     = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign nonempty = (count_r != '0);
  assign rd_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/siph_back.sv =====
// Back end: one SipRound per cycle over queued blocks (stalls while the
// digest waits), finalization, digest register. Depends on siph_pkg.
module siph_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  siph_pkg::q_entry_t q_entry,
  output logic               q_pop,
  input  logic [63:0]        key_low,
  input  logic [63:0]        key_high,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_digest,
  output siph_pkg::bk_stat_t stat
);
  import siph_pkg::*;

  bk_state_t   state_r, state_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  lanes_t      lanes_r, lanes_nxt;
  logic [63:0] m_cur_r, m_cur_nxt;
  logic [63:0] m1_r, m1_nxt;
  logic        pend_r, pend_nxt;
  logic        final_r, final_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] digest_r, digest_nxt;

  lanes_t      r_in, r_out, tmp;
  logic [63:0] m_first;

  assign r_out      = siph_round(r_in);
  assign out_valid  = out_valid_r;
  assign out_digest = digest_r;
  assign stat.idle   = (state_r == BK_IDLE);
  assign stat.in_fin = (state_r == BK_FIN);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lanes_nxt     = lanes_r;
    m_cur_nxt     = m_cur_r;
    m1_nxt        = m1_r;
    pend_nxt      = pend_r;
    final_nxt     = final_r;
    digest_nxt    = digest_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    r_in          = lanes_r;
    tmp           = r_out;
    m_first       = (q_entry.op == OP_FINAL) ? q_entry.m1 : q_entry.m0;

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_entry.start) begin
            r_in.v0 = key_low ^ SIP_C0;
            r_in.v1 = key_high ^ SIP_C1;
            r_in.v2 = key_low ^ SIP_C2;
            r_in.v3 = key_high ^ SIP_C3;
          end
          r_in.v3   = r_in.v3 ^ m_first;
          lanes_nxt = r_out;
          m_cur_nxt = m_first;
          m1_nxt    = q_entry.m1;
          pend_nxt  = (q_entry.op == OP_FINAL2);
          final_nxt = (q_entry.op != OP_ABSORB);
          cnt_nxt   = 2'd1;
          state_nxt = BK_BLOCK;
        end
      end
      BK_BLOCK: begin
        if (cnt_r == 2'd0) begin
          lanes_nxt = r_out;
          cnt_nxt   = 2'd1;
        end else begin
          tmp.v0 = r_out.v0 ^ m_cur_r;
          if (pend_r) begin
            // full last word done, length block follows
            tmp.v3    = r_out.v3 ^ m1_r;
            m_cur_nxt = m1_r;
            pend_nxt  = 1'b0;
            cnt_nxt   = 2'd0;
          end else if (final_r) begin
            tmp.v2    = r_out.v2 ^ FINAL_XOR;
            cnt_nxt   = 2'd0;
            state_nxt = BK_FIN;
          end else begin
            state_nxt = BK_IDLE;
          end
          lanes_nxt = tmp;
        end
      end
      BK_FIN: begin
        if (cnt_r != 2'd3) begin
          lanes_nxt = r_out;
          cnt_nxt   = cnt_r + 2'd1;
        end else if (!out_valid_r || out_ready) begin
          lanes_nxt     = r_out;
          digest_nxt    = r_out.v0 ^ r_out.v1 ^ r_out.v2 ^ r_out.v3;
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    lanes_r  <= lanes_nxt;
    m_cur_r  <= m_cur_nxt;
    m1_r     <= m1_nxt;
    digest_r <= digest_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= 2'd0;
      pend_r      <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
